[src/backtrack_choice_stack_core_defines.svh]
// ----------------------------------------------------------------------------
// Backtrack choice stack assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BACKTRACK_CHOICE_STACK_CORE_DEFINES_SVH
`define BACKTRACK_CHOICE_STACK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk and masked during reset.
`define BCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and masked during reset.
`define BCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bcs_pkg.sv]
// ----------------------------------------------------------------------------
// Backtrack choice stack package
// Word types, operation codes, controller states, command and status structs.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int INDEX_BITS  = 16;
    localparam int DEPTH_BITS  = $clog2(MAX_DEPTH + 1);
    localparam int CURSOR_BITS = DEPTH_BITS + 1;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_DESCEND = 3'd1,
        OP_NEXT    = 3'd2,
        OP_REWIND  = 3'd3,
        OP_QUERY   = 3'd4
    } op_e;

    typedef struct packed {
        logic [2:0]            op;
        logic [INDEX_BITS-1:0] num_alternatives;
    } in_word_t;

    typedef struct packed {
        logic signed [CURSOR_BITS-1:0] cursor_level;
        logic                          level_known;
        logic [INDEX_BITS-1:0]         choice_index;
        logic                          has_more;
        logic [DEPTH_BITS-1:0]         stack_depth;
        logic                          overflow;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_NEXT_RD,
        ST_NEXT_EVAL,
        ST_CUR_RD,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic next_rd;
        logic next_eval;
        logic cur_rd;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_next;
        logic stack_empty;
        logic exhausted;
        logic out_stall;
    } dp_stat_t;

endpackage

[src/backtrack_choice_stack_core.sv]
// Sequencing: add, descend, rewind and query go through execute, cursor read and output
// load after the word is accepted; a new word is accepted only after the result is loaded.
// Next exploration reads and evaluates stack levels until one is advanced or the stack ends
// empty; the single read port of the level RAM walks the stack one level a step.
// Reset: synchronous, active low; depth goes to 0 and cursor to -1, the RAM is not cleared.
// ----------------------------------------------------------------------------
// Backtrack choice stack core
// Stack of choice levels with a cursor, advanced like a mixed-radix counter.
// ----------------------------------------------------------------------------
module backtrack_choice_stack_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bcs_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bcs_pkg::out_word_t m_data
);

    import bcs_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bcs_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[src/bcs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/bcs_ctrl.sv]
// ----------------------------------------------------------------------------
// Backtrack choice stack controller
// Sequences one word through execute, stack walk for next, cursor read and output load.
// ----------------------------------------------------------------------------
module bcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bcs_pkg::dp_stat_t stat,
    output bcs_pkg::dp_cmd_t  cmd
);

    import bcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = stat.is_next ? ST_NEXT_RD : ST_CUR_RD;
            end
            ST_NEXT_RD: begin
                state_next = stat.stack_empty ? ST_CUR_RD : ST_NEXT_EVAL;
            end
            ST_NEXT_EVAL: begin
                state_next = stat.exhausted ? ST_NEXT_RD : ST_CUR_RD;
            end
            ST_CUR_RD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (!stat.out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.latch = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_NEXT_RD: begin
                cmd.next_rd = !stat.stack_empty;
            end
            ST_NEXT_EVAL: begin
                cmd.next_eval = 1'b1;
            end
            ST_CUR_RD: begin
                cmd.cur_rd = 1'b1;
            end
            ST_LOAD: begin
                cmd.load = !stat.out_stall;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

[src/bcs_datapath.sv]
// ----------------------------------------------------------------------------
// Backtrack choice stack datapath
// Depth and cursor registers, level RAM, advance logic and output register.
// ----------------------------------------------------------------------------
module bcs_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  bcs_pkg::dp_cmd_t   cmd,
    output bcs_pkg::dp_stat_t  stat,
    input  bcs_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bcs_pkg::out_word_t m_data
);

    import bcs_pkg::*;

    localparam int DEP_W  = DEPTH_BITS;
    localparam int CUR_W  = CURSOR_BITS;
    localparam int ADDR_W = $clog2(MAX_DEPTH);
    localparam int WORD_W = 2 * INDEX_BITS;

    logic [2:0]              op_reg;
    logic [INDEX_BITS-1:0]   num_reg;
    logic [DEP_W-1:0]        depth_reg,  depth_next;
    logic signed [CUR_W-1:0] cursor_reg, cursor_next;
    logic                    more_reg,   more_next;
    logic                    ovf_reg,    ovf_next;
    logic                    m_valid_reg;
    out_word_t               m_data_reg;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [WORD_W-1:0]       wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic [WORD_W-1:0]       rd_data;

    logic [DEP_W-1:0]        depth_dec;
    logic [ADDR_W-1:0]       top_addr;
    logic [INDEX_BITS-1:0]   rd_choice;
    logic [INDEX_BITS-1:0]   rd_count;
    logic [INDEX_BITS-1:0]   choice_inc;
    logic [INDEX_BITS-1:0]   cnt_in;
    logic [INDEX_BITS-1:0]   cnt_fix;
    logic                    exhausted;
    logic                    full;
    logic                    known;
    logic                    is_add;
    logic signed [31:0]      cur_ext;
    logic [31:0]             depth_ext;
    logic [31:0]             choice_ext;

    bcs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_DEPTH)
    ) u_level_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign depth_dec  = depth_reg - DEP_W'(1);
    assign top_addr   = depth_dec[ADDR_W-1:0];
    assign rd_choice  = rd_data[INDEX_BITS-1:0];
    assign rd_count   = rd_data[WORD_W-1:INDEX_BITS];
    assign choice_inc = rd_choice + INDEX_BITS'(1);
    assign exhausted  = (choice_inc >= rd_count) || (choice_inc == '0);
    assign cnt_in     = num_reg;
    assign cnt_fix    = (cnt_in == '0) ? INDEX_BITS'(1) : cnt_in;
    assign full       = (depth_reg == DEP_W'(MAX_DEPTH));
    assign known      = !cursor_reg[CUR_W-1] && (cursor_reg[DEP_W-1:0] < depth_reg);
    assign is_add     = (op_reg == OP_ADD);

    assign wr_en   = (cmd.exec && is_add && !full) || (cmd.next_eval && !exhausted);
    assign wr_addr = cmd.exec ? depth_reg[ADDR_W-1:0] : top_addr;
    assign wr_data = cmd.exec ? {cnt_fix, {INDEX_BITS{1'b0}}} : {rd_count, choice_inc};
    assign rd_en   = cmd.next_rd || cmd.cur_rd;
    assign rd_addr = cmd.next_rd ? top_addr : cursor_reg[ADDR_W-1:0];

    always_comb begin
        depth_next  = depth_reg;
        cursor_next = cursor_reg;
        more_next   = more_reg;
        ovf_next    = ovf_reg;
        if (cmd.latch) begin
            more_next = 1'b0;
            ovf_next  = 1'b0;
        end
        if (cmd.exec) begin
            unique case (op_reg)
                OP_ADD: begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        cursor_next = $signed({1'b0, depth_reg});
                        depth_next  = depth_reg + DEP_W'(1);
                    end
                end
                OP_DESCEND: begin
                    if (cursor_reg < $signed(CUR_W'(MAX_DEPTH))) begin
                        cursor_next = cursor_reg + CUR_W'(1);
                    end
                end
                OP_REWIND: begin
                    cursor_next = '0;
                end
                default: begin
                    cursor_next = cursor_reg;
                end
            endcase
        end
        if (cmd.next_eval) begin
            if (exhausted) begin
                depth_next = depth_dec;
            end else begin
                cursor_next = '0;
                more_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            cursor_reg  <= '1;
            more_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            depth_reg  <= depth_next;
            cursor_reg <= cursor_next;
            more_reg   <= more_next;
            ovf_reg    <= ovf_next;
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign cur_ext    = 32'(cursor_reg);
    assign depth_ext  = 32'(depth_reg);
    assign choice_ext = known ? 32'(rd_choice) : 32'd0;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg  <= s_data.op;
            num_reg <= s_data.num_alternatives;
        end
        if (cmd.load) begin
            m_data_reg.cursor_level <= cur_ext[CUR_W-1:0];
            m_data_reg.level_known  <= known;
            m_data_reg.choice_index <= choice_ext[INDEX_BITS-1:0];
            m_data_reg.has_more     <= more_reg;
            m_data_reg.stack_depth  <= depth_ext[DEP_W-1:0];
            m_data_reg.overflow     <= ovf_reg;
        end
    end

    assign stat.is_next     = (op_reg == OP_NEXT);
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.exhausted   = exhausted;
    assign stat.out_stall   = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/bcs_checker.sv]
// ----------------------------------------------------------------------------
// Backtrack choice stack checker
// Port-level properties of the handshakes and result words, bound to the core.
// ----------------------------------------------------------------------------
`include "backtrack_choice_stack_core_defines.svh"

module bcs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bcs_pkg::out_word_t m_data
);

    logic out_stall;
    logic in_accept;
    logic shown_known;
    logic shown_unknown;
    logic in_stack;

    assign out_stall     = m_valid && !m_ready;
    assign in_accept     = s_valid && s_ready;
    assign shown_known   = m_valid && m_data.level_known;
    assign shown_unknown = m_valid && !m_data.level_known;
    assign in_stack      = !m_data.cursor_level[7]
                           && (m_data.cursor_level[6:0] < m_data.stack_depth);

    `BCS_ASSERT_NEXT(a_out_hold, out_stall, m_valid && $stable(m_data), "result word changed")
    `BCS_ASSERT_NEXT(a_one_word, in_accept, !s_ready, "input accepted in consecutive cycles")
    `BCS_ASSERT_NOW(a_known_range, shown_known, in_stack, "known level outside the stack")
    `BCS_ASSERT_NOW(a_unknown_zero, shown_unknown, m_data.choice_index == '0, "choice shown")
    `BCS_ASSERT_NOW(a_ovf_excl, m_valid && m_data.overflow, !m_data.has_more, "overflow with more")

endmodule

bind backtrack_choice_stack_core bcs_checker u_bcs_checker (.*);
